// ===== design/bls_pkg.sv =====
// Package for the line stepper: widths, stream packing and the command
// record passed from the classifier to the stepper. No dependencies.
package bls_pkg;

   localparam int COORD_BITS    = 10;
   localparam int DELTA_BITS    = COORD_BITS + 1;
   localparam int ERR_BITS      = COORD_BITS + 4;
   localparam int COLOR_BITS    = 24;
   localparam int REQ_DATA_BITS = ((4 * COORD_BITS + COLOR_BITS + 7) / 8) * 8;
   localparam int RSP_PAY_BITS  = 2 * COORD_BITS + COLOR_BITS;
   localparam int RSP_DATA_BITS = ((RSP_PAY_BITS + 7) / 8) * 8;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      MODE_START   = 1'b0,
      MODE_ADVANCE = 1'b1
   } mode_type;

   typedef struct packed {
      mode_type                     mode;
      logic [COORD_BITS-1:0]        cur_x;
      logic [COORD_BITS-1:0]        cur_y;
      logic [COORD_BITS-1:0]        stop_x;
      logic [COORD_BITS-1:0]        stop_y;
      logic [DELTA_BITS-1:0]        delta_x;
      logic [DELTA_BITS-1:0]        delta_y;
      logic signed [ERR_BITS-1:0]   err_term;
      logic                         steep;
      logic                         y_down;
      logic [COLOR_BITS-1:0]        color;
   } cmd_type;

endpackage

// ===== design/bls_front.sv =====
// Front end: accepts request transfers and classifies start items into a
// ready-to-step command record. Depends on bls_pkg.
module bls_front
   import bls_pkg::*;
(
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   input  logic                     req_tuser,
   input  logic                     queue_full,
   output logic                     push,
   output cmd_type                  push_cmd
);

   logic [COORD_BITS-1:0]      ax, ay, bx, by;
   logic [COORD_BITS-1:0]      lo_x, lo_y, hi_x, hi_y;
   logic [DELTA_BITS-1:0]      dx, dy;
   logic                       y_down, steep;
   logic signed [ERR_BITS-1:0] dx_e, dy_e;

   assign ax = req_tdata[COORD_BITS-1:0];
   assign ay = req_tdata[2*COORD_BITS-1:COORD_BITS];
   assign bx = req_tdata[3*COORD_BITS-1:2*COORD_BITS];
   assign by = req_tdata[4*COORD_BITS-1:3*COORD_BITS];

   always_comb begin
      if (ax > bx) begin
         lo_x = bx;
         lo_y = by;
         hi_x = ax;
         hi_y = ay;
      end else begin
         lo_x = ax;
         lo_y = ay;
         hi_x = bx;
         hi_y = by;
      end
   end

   assign dx     = DELTA_BITS'(hi_x) - DELTA_BITS'(lo_x);
   assign y_down = hi_y < lo_y;
   assign dy     = y_down ? DELTA_BITS'(lo_y) - DELTA_BITS'(hi_y)
                          : DELTA_BITS'(hi_y) - DELTA_BITS'(lo_y);
   assign steep  = dy > dx;
   assign dx_e   = ERR_BITS'(dx);
   assign dy_e   = ERR_BITS'(dy);

   always_comb begin
      push_cmd.mode     = mode_type'(req_tuser);
      push_cmd.cur_x    = lo_x;
      push_cmd.cur_y    = lo_y;
      push_cmd.stop_x   = hi_x;
      push_cmd.stop_y   = hi_y;
      push_cmd.delta_x  = dx;
      push_cmd.delta_y  = dy;
      push_cmd.err_term = steep ? dy_e - (dx_e <<< 1) : (dy_e <<< 1) - dx_e;
      push_cmd.steep    = steep;
      push_cmd.y_down   = y_down;
      push_cmd.color    = req_tdata[4*COORD_BITS+COLOR_BITS-1:4*COORD_BITS];
   end

   assign req_tready = !queue_full;
   assign push       = req_tvalid && req_tready;

endmodule

// ===== design/bls_queue.sv =====
// Short command queue between the classifier and the stepper.
// Depends on bls_pkg.
module bls_queue
   import bls_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    empty,
   output cmd_type head_cmd
);

   cmd_type              entries_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;

   assign full     = count_ff == QCNT_BITS'(QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign head_cmd = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("Queue written while full.");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("Queue read while empty.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_BITS'(QUEUE_DEPTH))
      else $error("Queue count out of range.");

endmodule

// ===== design/bls_back.sv =====
// Back end: holds the active line, steps the error recurrence once per
// command and drives the result register. Depends on bls_pkg.
module bls_back
   import bls_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     empty,
   input  cmd_type                  head_cmd,
   output logic                     pop,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                     rsp_tuser,
   output logic                     rsp_tlast
);

   logic [COORD_BITS-1:0]      cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [COORD_BITS-1:0]      stop_x_ff, stop_x_in, stop_y_ff, stop_y_in;
   logic [DELTA_BITS-1:0]      dx_ff, dx_in, dy_ff, dy_in;
   logic signed [ERR_BITS-1:0] err_ff, err_in;
   logic                       steep_ff, steep_in, y_down_ff, y_down_in;
   logic [COLOR_BITS-1:0]      color_ff, color_in;
   logic                       busy_ff, busy_in;

   logic                       out_valid_ff, out_valid_in;
   logic [RSP_PAY_BITS-1:0]    out_data_ff, out_data_in;
   logic                       out_pix_ff, out_pix_in;
   logic                       out_last_ff, out_last_in;

   logic                       load, emit, fin;
   logic [COORD_BITS-1:0]      sx, sy, sstop_x, sstop_y, y_step;
   logic [DELTA_BITS-1:0]      sdx, sdy;
   logic signed [ERR_BITS-1:0] serr, dx2, dy2, err_mid;
   logic                       ssteep, sy_down;
   logic [COLOR_BITS-1:0]      scolor;

   assign pop  = !empty && (!out_valid_ff || rsp_tready);
   assign load = pop && (head_cmd.mode == MODE_START);
   assign emit = load || (pop && busy_ff);

   always_comb begin
      if (load) begin
         sx      = head_cmd.cur_x;
         sy      = head_cmd.cur_y;
         sstop_x = head_cmd.stop_x;
         sstop_y = head_cmd.stop_y;
         sdx     = head_cmd.delta_x;
         sdy     = head_cmd.delta_y;
         serr    = head_cmd.err_term;
         ssteep  = head_cmd.steep;
         sy_down = head_cmd.y_down;
         scolor  = head_cmd.color;
      end else begin
         sx      = cur_x_ff;
         sy      = cur_y_ff;
         sstop_x = stop_x_ff;
         sstop_y = stop_y_ff;
         sdx     = dx_ff;
         sdy     = dy_ff;
         serr    = err_ff;
         ssteep  = steep_ff;
         sy_down = y_down_ff;
         scolor  = color_ff;
      end
   end

   assign fin    = ssteep ? (sy == sstop_y) : (sx == sstop_x);
   assign dx2    = ERR_BITS'(sdx) <<< 1;
   assign dy2    = ERR_BITS'(sdy) <<< 1;
   assign y_step = sy_down ? sy - 1'b1 : sy + 1'b1;

   always_comb begin
      cur_x_in  = sx;
      cur_y_in  = sy;
      stop_x_in = sstop_x;
      stop_y_in = sstop_y;
      dx_in     = sdx;
      dy_in     = sdy;
      steep_in  = ssteep;
      y_down_in = sy_down;
      color_in  = scolor;
      busy_in   = busy_ff;
      err_mid   = serr;
      err_in    = serr;
      if (emit) begin
         busy_in = !fin;
         if (!fin) begin
            if (!ssteep) begin
               if (serr > 0) begin
                  cur_y_in = y_step;
                  err_mid  = serr - dx2;
               end
               cur_x_in = sx + 1'b1;
               err_in   = err_mid + dy2;
            end else begin
               if (serr < 0) begin
                  cur_x_in = sx + 1'b1;
                  err_mid  = serr + dy2;
               end
               cur_y_in = y_step;
               err_in   = err_mid - dx2;
            end
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_pix_in   = out_pix_ff;
      out_last_in  = out_last_ff;
      if (pop) begin
         out_valid_in = 1'b1;
         out_pix_in   = emit;
         out_last_in  = emit && fin;
         out_data_in  = emit ? {scolor, sy, sx} : '0;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      stop_x_ff   <= stop_x_in;
      stop_y_ff   <= stop_y_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      err_ff      <= err_in;
      steep_ff    <= steep_in;
      y_down_ff   <= y_down_in;
      color_ff    <= color_in;
      out_data_ff <= out_data_in;
      out_pix_ff  <= out_pix_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'(out_data_ff);
   assign rsp_tuser  = out_pix_ff;
   assign rsp_tlast  = out_last_ff;

   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      (emit && fin) |=> !busy_ff)
      else $error("Line still active after its last pixel.");

   a_idle_result_empty: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_pix_ff) |-> (out_data_ff == '0 && !out_last_ff))
      else $error("Result without a pixel carries data.");

   a_last_needs_pixel: assert property (@(posedge clock) disable iff (reset)
      out_last_ff |-> out_pix_ff)
      else $error("Last flag set on a result without a pixel.");

endmodule

// ===== design/bresenham_line_stepper_top.sv =====
// Top level of the line stepper: classifier, command queue and stepper.
// Depends on bls_pkg, bls_front, bls_queue and bls_back.
//
//   Channel  Direction  Sideband            Content
//   req      in         tuser = mode        tdata: start_x, start_y, end_x, end_y, line_color
//   rsp      out        tuser = pixel_valid tdata: pixel_x, pixel_y, pixel_color; tlast = last
//
// One pixel per cycle is sustained while the queue holds commands and the response side
// accepts: the stepper updates the error term and coordinates with one compare and two adds per cycle.
// A request is registered in the command queue and then in the response register.
// Reset clears the active line, the queue and the response register.
// The two-entry queue lets the request side keep moving while a response stalls, until it fills.
module bresenham_line_stepper_top
   import bls_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,  // start_x, start_y, end_x, end_y, line_color
   input  logic                     req_tuser,  // mode
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,  // pixel_x, pixel_y, pixel_color, zero pad
   output logic                     rsp_tuser,  // pixel_valid
   output logic                     rsp_tlast
);

   logic    queue_full, queue_empty, push, pop;
   cmd_type push_cmd, head_cmd;

   bls_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   bls_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .full     (queue_full),
      .empty    (queue_empty),
      .head_cmd (head_cmd)
   );

   bls_back u_back (
      .clock      (clock),
      .reset      (reset),
      .empty      (queue_empty),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for bresenham_line_stepper_top: random line requests with stalls on both
// stream sides, every pixel compared against a scoreboard that rasterizes the same lines.
// Depends on bls_pkg and the line stepper RTL.
module tb_top;
   import bls_pkg::*;

   localparam int TOTAL_ITEMS = 1550;
   localparam int IDLE_LIMIT  = 4000;
   localparam int HOLD_CYCLES = 300;
   localparam int MAX_COORD   = (1 << COORD_BITS) - 1;

   typedef struct {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COLOR_BITS-1:0] color;
      logic                  valid;
      logic                  last;
   } pixel_type;

   class line_scoreboard;
      pixel_type             pending_pixels[$];
      logic [COORD_BITS-1:0] cur_x, cur_y, stop_x, stop_y;
      logic [COLOR_BITS-1:0] color;
      int                    delta_x, delta_y, err_term;
      bit                    steep, y_down, busy;
      int                    errors, lines, pixels, empties;

      function new();
         cur_x = '0;
         cur_y = '0;
         stop_x = '0;
         stop_y = '0;
         color = '0;
         delta_x = 0;
         delta_y = 0;
         err_term = 0;
         steep = 0;
         y_down = 0;
         busy = 0;
         errors = 0;
         lines = 0;
         pixels = 0;
         empties = 0;
      endfunction

      function pixel_type next_pixel();
         pixel_type p;
         bit        fin;
         fin = steep ? (cur_y == stop_y) : (cur_x == stop_x);
         p.x = cur_x;
         p.y = cur_y;
         p.color = color;
         p.valid = 1'b1;
         p.last = fin;
         pixels++;
         if (fin) begin
            busy = 0;
         end else if (!steep) begin
            if (err_term > 0) begin
               cur_y = y_down ? cur_y - 1'b1 : cur_y + 1'b1;
               err_term -= 2 * delta_x;
            end
            cur_x = cur_x + 1'b1;
            err_term += 2 * delta_y;
         end else begin
            if (err_term < 0) begin
               cur_x = cur_x + 1'b1;
               err_term += 2 * delta_y;
            end
            cur_y = y_down ? cur_y - 1'b1 : cur_y + 1'b1;
            err_term -= 2 * delta_x;
         end
         return p;
      endfunction

      function void note_request(mode_type mode, logic [REQ_DATA_BITS-1:0] data);
         logic [COORD_BITS-1:0] ax, ay, bx, by, t;
         pixel_type             p;
         if (mode == MODE_START) begin
            ax = data[0 +: COORD_BITS];
            ay = data[COORD_BITS +: COORD_BITS];
            bx = data[2*COORD_BITS +: COORD_BITS];
            by = data[3*COORD_BITS +: COORD_BITS];
            color = data[4*COORD_BITS +: COLOR_BITS];
            if (ax > bx) begin
               t = ax; ax = bx; bx = t;
               t = ay; ay = by; by = t;
            end
            cur_x = ax;
            cur_y = ay;
            stop_x = bx;
            stop_y = by;
            delta_x = int'(bx) - int'(ax);
            y_down = by < ay;
            delta_y = y_down ? int'(ay) - int'(by) : int'(by) - int'(ay);
            steep = delta_y > delta_x;
            err_term = steep ? delta_y - 2 * delta_x : 2 * delta_y - delta_x;
            busy = 1;
            lines++;
            p = next_pixel();
         end else if (busy) begin
            p = next_pixel();
         end else begin
            p = '{x: '0, y: '0, color: '0, valid: 1'b0, last: 1'b0};
            empties++;
         end
         pending_pixels.push_back(p);
      endfunction

      function void compare(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_pixel(logic [RSP_DATA_BITS-1:0] data, logic valid, logic last);
         pixel_type p;
         if (pending_pixels.size() == 0) begin
            $display("%0t: response with no pixel pending, expected none, actual %0h", $time, data);
            errors++;
            return;
         end
         p = pending_pixels.pop_front();
         compare("pixel_x", 32'(p.x), 32'(data[0 +: COORD_BITS]));
         compare("pixel_y", 32'(p.y), 32'(data[COORD_BITS +: COORD_BITS]));
         compare("pixel_color", 32'(p.color), 32'(data[2*COORD_BITS +: COLOR_BITS]));
         compare("pad", 0, 32'(data >> RSP_PAY_BITS));
         compare("pixel_valid", 32'(p.valid), 32'(valid));
         compare("last", 32'(p.last), 32'(last));
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;  // start_x, start_y, end_x, end_y, line_color
   logic                     req_tuser = 1'b0; // mode
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b1;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;       // pixel_x, pixel_y, pixel_color, zero pad
   logic                     rsp_tuser;       // pixel_valid
   logic                     rsp_tlast;

   line_scoreboard board;
   int             items_sent = 0;
   int             idle_cycles = 0;
   bit             quiet = 0;
   bit             hold_request = 0;
   bit             hold_issued = 0;

   bresenham_line_stepper_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req_tvalid && req_tready)
            board.note_request(mode_type'(req_tuser), req_tdata);
         if (rsp_tvalid && rsp_tready)
            board.check_pixel(rsp_tdata, rsp_tuser, rsp_tlast);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   // The long hold lets the command queue fill so that req_tready drops.
   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else begin
            @(posedge clock);
         end
      end
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("FAIL bresenham_line_stepper_top");
      $finish;
   end

   task automatic send(input mode_type mode, input logic [REQ_DATA_BITS-1:0] data);
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= data;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (!quiet && $urandom_range(0, 9) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   task automatic draw(input int sx, input int sy, input int ex, input int ey,
                       input logic [COLOR_BITS-1:0] color, input int advances);
      send(MODE_START, {color, COORD_BITS'(ey), COORD_BITS'(ex), COORD_BITS'(sy),
                        COORD_BITS'(sx)});
      repeat (advances) send(MODE_ADVANCE, {$urandom, $urandom});
   endtask

   function automatic int pick_end(int s, int d);
      if (s + d > MAX_COORD) return s - d;
      if (s - d < 0) return s + d;
      return $urandom_range(0, 1) ? s + d : s - d;
   endfunction

   // Mostly complete short lines; some overrun into empty advances, some are cut short
   // by the next start.
   task automatic random_line();
      int sx, sy, ex, ey, reach, mx, my, steps, advances, pick;
      pick = $urandom_range(0, 99);
      reach = (pick < 90) ? 12 : ((pick < 98) ? 60 : 400);
      sx = $urandom_range(0, MAX_COORD);
      sy = $urandom_range(0, MAX_COORD);
      mx = $urandom_range(0, reach);
      my = $urandom_range(0, reach);
      case ($urandom_range(0, 7))
         0: my = 0;
         1: mx = 0;
         2: my = mx;
         3: begin
            mx = 0;
            my = 0;
         end
         default: ;
      endcase
      ex = pick_end(sx, mx);
      ey = pick_end(sy, my);
      steps = (mx > my) ? mx : my;
      pick = $urandom_range(0, 99);
      if (pick < 8)
         advances = steps + $urandom_range(1, 3);
      else if (pick < 20)
         advances = $urandom_range(0, steps);
      else
         advances = steps;
      draw(sx, sy, ex, ey, COLOR_BITS'($urandom), advances);
   endtask

   initial begin
      board = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send(MODE_ADVANCE, '1);
      draw(MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD, 24'hFFFFFF, 1);
      draw(0, 0, 3, 0, 24'h000000, 3);
      draw(5, MAX_COORD, 5, MAX_COORD - 3, 24'hA5A5A5, 3);
      draw(MAX_COORD, 0, MAX_COORD - 4, 2, 24'h5A5A5A, 4);
      draw(0, 0, 2, 2, 24'h123456, 2);
      draw(10, 10, 11, 13, 24'hFEDCBA, 1);
      draw(MAX_COORD - 2, 2, MAX_COORD, 0, 24'h00FF00, 2);

      while (items_sent < TOTAL_ITEMS) begin
         if (items_sent >= 400 && !hold_issued) begin
            hold_issued = 1;
            hold_request = 1;
         end
         quiet = items_sent > TOTAL_ITEMS - 250;
         if ($urandom_range(0, 19) == 0)
            send(MODE_ADVANCE, {$urandom, $urandom});
         else
            random_line();
      end
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending_pixels.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Drew %0d lines over %0d requests: %0d pixels and %0d empty advances checked.",
               board.lines, items_sent, board.pixels, board.empties);
      if (board.errors == 0)
         $display("PASS bresenham_line_stepper_top");
      else
         $display("FAIL bresenham_line_stepper_top");
      $finish;
   end

endmodule
